>>> design/fepm_pkg.sv
package fepm_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 12;
  localparam int SUM_W          = 32;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST  = CFG_W'(720);
  localparam logic [CFG_W-1:0] ACTIVE_HEIGHT_RST = CFG_W'(576);
  localparam logic [CFG_W-1:0] PADDED_WIDTH_RST  = CFG_W'(720);
  localparam logic [CFG_W-1:0] PADDED_HEIGHT_RST = CFG_W'(576);

  localparam logic [PIX_W-1:0] MEAN_MAX = {PIX_W{1'b1}};

  typedef enum logic [1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1,
    REG_PADDED_WIDTH  = 2'd2,
    REG_PADDED_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

endpackage

>>> design/fepm_line_buf.sv
module fepm_line_buf #(
  parameter int DEPTH = fepm_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(fepm_pkg::MAX_WIDTH_DEF)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [fepm_pkg::PIX_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fepm_pkg::PIX_W-1:0] wr_data
);
  import fepm_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/fepm_mean_div.sv
module fepm_mean_div #(
  parameter int DIV_W = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fepm_pkg::SUM_W-1:0] sum,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [fepm_pkg::PIX_W-1:0] mean
);
  import fepm_pkg::*;

  localparam int DSH_W  = DIV_W + PIX_W;
  localparam int GW     = (DSH_W > SUM_W) ? DSH_W : SUM_W;
  localparam int STEP_W = $clog2(PIX_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PIX_W);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [PIX_W-1:0]  q_r;
  logic [PIX_W-1:0]  mean_r;
  logic              done_r;
  logic              ge;
  logic [PIX_W-1:0]  q_nxt;

  assign ge    = GW'(rem_r) >= GW'(dsh_r);
  assign q_nxt = {q_r[PIX_W-2:0], ge};

  // Step zero checks for a quotient above the 8-bit range, then one bit a step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == '0) begin
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end else if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= sum;
      dsh_r <= {divisor, {PIX_W{1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      if (step_r == '0) begin
        if (ge) begin
          mean_r <= MEAN_MAX;
        end
      end else begin
        q_r <= q_nxt;
        if (ge) begin
          rem_r <= rem_r - SUM_W'(dsh_r);
        end
        if (step_r == LAST_STEP) begin
          mean_r <= q_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign mean = mean_r;

endmodule

>>> design/frame_edge_pad_and_mean.sv
// Flow: a beat is accepted only in the idle state, which also reads the line buffer;
//   the pixel is committed, written back and registered into the output slot once
//   that slot is free, so no new pixel is taken before the last is committed; on the
//   last padded position the output waits for the mean divider, one pass per frame.
// Reset (rst_n, synchronous, active low) restores the registers to 720 x 576 and
//   clears counters, sum and the left pixel; the line buffer is not cleared.
module frame_edge_pad_and_mean #(
  parameter int MAX_WIDTH  = fepm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fepm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fepm_pkg::PIX_W-1:0]  in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fepm_pkg::PIX_W-1:0]  out_pixel_out,
  output logic                        out_frame_end,
  output logic [fepm_pkg::PIX_W-1:0]  out_frame_mean,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fepm_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [fepm_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [fepm_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import fepm_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PW_W   = $clog2(MAX_WIDTH + 1);
  localparam int PH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int PMAX_W = (PW_W > PH_W) ? PW_W : PH_W;
  localparam int CW     = ((PMAX_W > CFG_W) ? PMAX_W : CFG_W) + 1;
  localparam int PROD_W = PW_W + PH_W;

  // configuration registers
  logic [CFG_W-1:0] act_w_r, act_h_r, pad_w_r, pad_h_r;
  reg_idx_t         wr_idx;
  reg_idx_t         rd_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_idx     = reg_idx_t'(cfg_paddr[APB_AW-1:2]);
  assign rd_idx     = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= ACTIVE_WIDTH_RST;
      act_h_r <= ACTIVE_HEIGHT_RST;
      pad_w_r <= PADDED_WIDTH_RST;
      pad_h_r <= PADDED_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_ACTIVE_WIDTH:  act_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_ACTIVE_HEIGHT: act_h_r <= cfg_pwdata[CFG_W-1:0];
        REG_PADDED_WIDTH:  pad_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_PADDED_HEIGHT: pad_h_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rd_idx)
      REG_ACTIVE_WIDTH:  cfg_prdata = APB_DW'(act_w_r);
      REG_ACTIVE_HEIGHT: cfg_prdata = APB_DW'(act_h_r);
      REG_PADDED_WIDTH:  cfg_prdata = APB_DW'(pad_w_r);
      REG_PADDED_HEIGHT: cfg_prdata = APB_DW'(pad_h_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // saturate sizes: padded into 1..max, active into 1..padded
  logic [CW-1:0] pw_c, ph_c, aw_c, ah_c;

  always_comb begin
    pw_c = CW'(pad_w_r);
    if (pw_c == '0) begin
      pw_c = CW'(1);
    end else if (pw_c > CW'(MAX_WIDTH)) begin
      pw_c = CW'(MAX_WIDTH);
    end
    ph_c = CW'(pad_h_r);
    if (ph_c == '0) begin
      ph_c = CW'(1);
    end else if (ph_c > CW'(MAX_HEIGHT)) begin
      ph_c = CW'(MAX_HEIGHT);
    end
    aw_c = CW'(act_w_r);
    if (aw_c == '0) begin
      aw_c = CW'(1);
    end else if (aw_c > pw_c) begin
      aw_c = pw_c;
    end
    ah_c = CW'(act_h_r);
    if (ah_c == '0) begin
      ah_c = CW'(1);
    end else if (ah_c > ph_c) begin
      ah_c = ph_c;
    end
  end

  // control and datapath state
  state_t           state_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] pin_r;
  logic [SUM_W-1:0] sum_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_end_r;
  logic [PIX_W-1:0] out_mean_r;

  logic             in_acc;
  logic             commit;
  logic             out_set;
  logic [PIX_W-1:0] row_pix;
  logic [PIX_W-1:0] pix;
  logic             last_col, last_row, frame_done;
  logic [SUM_W-1:0] sum_nxt;
  logic [PROD_W-1:0] area;
  logic             div_done;
  logic [PIX_W-1:0] div_mean;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  // commit only when the output slot is empty or being emptied this cycle
  assign commit   = (state_r == S_CALC) && (!out_valid_r || out_ready);
  // load a new beat into the output slot; a frame end waits for the divider
  assign out_set  = (commit && !frame_done) || (state_r == S_DIV && div_done);

  always_comb begin
    if (CW'(row_r) >= ah_c) begin
      pix = row_pix;
    end else if (CW'(col_r) >= aw_c) begin
      pix = left_r;
    end else begin
      pix = pin_r;
    end
  end

  assign last_col   = (CW'(col_r) + CW'(1)) >= pw_c;
  assign last_row   = (CW'(row_r) + CW'(1)) >= ph_c;
  assign frame_done = last_col && last_row;
  assign sum_nxt    = sum_r + SUM_W'(pix);
  assign area       = PROD_W'(pw_c[PW_W-1:0]) * PROD_W'(ph_c[PH_W-1:0]);

  fepm_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (row_pix),
    .wr_en   (commit),
    .wr_addr (col_r),
    .wr_data (pix)
  );

  fepm_mean_div #(
    .DIV_W (PROD_W)
  ) u_mean_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (commit && frame_done),
    .sum     (sum_nxt),
    .divisor (area),
    .done    (div_done),
    .mean    (div_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (commit) begin
            left_r <= pix;
            if (last_col) begin
              col_r <= '0;
              if (last_row) begin
                row_r   <= '0;
                sum_r   <= '0;
                state_r <= S_DIV;
              end else begin
                row_r   <= row_r + 1'b1;
                sum_r   <= sum_nxt;
                state_r <= S_IDLE;
              end
            end else begin
              col_r   <= col_r + 1'b1;
              sum_r   <= sum_nxt;
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pin_r <= in_pixel_in;
    end
    if (commit) begin
      out_pix_r  <= pix;
      out_end_r  <= frame_done;
      out_mean_r <= '0;
    end
    if (state_r == S_DIV && div_done) begin
      out_mean_r <= div_mean;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_end  = out_end_r;
  assign out_frame_mean = out_mean_r;

endmodule
